### hw/rtl/frequent_items_counter_summary_defines.svh
// Assertion helpers; every use sits in a module with clk and rst_n.
`ifndef FREQUENT_ITEMS_COUNTER_SUMMARY_DEFINES_SVH
`define FREQUENT_ITEMS_COUNTER_SUMMARY_DEFINES_SVH

// condition must hold at every edge out of reset
`define FICS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FICS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/fics_pkg.sv
package fics_pkg;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_NUM_COUNTERS = '0;
  localparam logic [4:0] NUM_COUNTERS_RESET = 5'd16;

  typedef enum logic {
    OP_ABSORB,
    OP_ABSORB_EMIT
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [31:0] item_value;
    logic        end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [31:0] candidate_value;
    logic [31:0] candidate_count;
    logic        table_empty;
    logic        last_in_run;
  } out_item_t;

endpackage

### hw/rtl/fics_front.sv
module fics_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  fics_pkg::in_item_t     in_data,
  output logic                   cmd_valid,
  input  logic                   cmd_take,
  output logic [VALUE_WIDTH-1:0] cmd_value,
  output fics_pkg::op_t          cmd_op
);
  import fics_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q_r [2];
  op_t                    op_q_r  [2];
  logic                   wr_ptr_r, rd_ptr_r;
  logic [1:0]             count_r, count_nxt;
  logic                   push, pop;

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd_value = val_q_r[rd_ptr_r];
  assign cmd_op    = op_q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  // only the low bits of the value take part in matching
  always_ff @(posedge clk) begin
    if (push) begin
      val_q_r[wr_ptr_r] <= VALUE_WIDTH'(in_data.item_value);
      op_q_r[wr_ptr_r]  <= in_data.end_of_stream ? OP_ABSORB_EMIT : OP_ABSORB;
    end
  end

`include "frequent_items_counter_summary_defines.svh"
  `FICS_ASSERT_ALWAYS(a_cnt_bound, count_r != 2'd3, "queue count out of range")
  `FICS_ASSERT_NEXT(a_cnt_up, push && !pop, count_r == $past(count_r) + 2'd1, "push lost")
  `FICS_ASSERT_NEXT(a_cnt_dn, pop && !push, count_r == $past(count_r) - 2'd1, "pop lost")

endmodule

### hw/rtl/fics_back.sv
module fics_back #(
  parameter int MAX_COUNTERS = 16,
  parameter int VALUE_WIDTH  = 32,
  parameter int COUNT_WIDTH  = 32,
  parameter int KW           = $clog2(MAX_COUNTERS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [KW-1:0]          k_eff,
  input  logic                   cfg_clear,
  input  logic                   cmd_valid,
  output logic                   cmd_take,
  input  logic [VALUE_WIDTH-1:0] cmd_value,
  input  fics_pkg::op_t          cmd_op,
  output logic                   out_valid,
  input  logic                   out_stall,
  output fics_pkg::out_item_t    out_data
);
  import fics_pkg::*;

  localparam int IW = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [VALUE_WIDTH-1:0] keys_r [MAX_COUNTERS];
  logic [COUNT_WIDTH-1:0] cnt_r  [MAX_COUNTERS];

  bk_state_t state_r, state_nxt;
  logic [IW-1:0] emit_idx_r, emit_idx_nxt;
  logic out_valid_r;
  out_item_t out_data_r, emit_item;

  logic [MAX_COUNTERS-1:0] active, held, match, free, free_oh, above;
  logic any_match, any_free, any_held, any_above;
  logic do_absorb, emit_load, emit_last, clear_all, out_free;

  for (genvar i = 0; i < MAX_COUNTERS; i++) begin : g_slot
    assign active[i] = 32'(i) < 32'(k_eff);
    assign held[i]   = (cnt_r[i] != '0);
    assign match[i]  = active[i] && held[i] && (keys_r[i] == cmd_value);
    assign free[i]   = active[i] && !held[i];
    assign above[i]  = held[i] && (32'(i) > 32'(emit_idx_r));
  end

  // lowest free slot as a one-hot
  assign free_oh   = free & (~free + MAX_COUNTERS'(1));
  assign any_match = |match;
  assign any_free  = |free;
  assign any_held  = |held;
  assign any_above = |above;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    emit_idx_nxt = emit_idx_r;
    cmd_take     = 1'b0;
    do_absorb    = 1'b0;
    emit_load    = 1'b0;
    emit_last    = 1'b0;
    emit_item    = '0;
    unique case (state_r)
      BK_RUN: begin
        if (cmd_valid) begin
          cmd_take  = 1'b1;
          do_absorb = 1'b1;
          if (cmd_op == OP_ABSORB_EMIT) begin
            state_nxt    = BK_EMIT;
            emit_idx_nxt = '0;
          end
        end
      end
      BK_EMIT: begin
        priority if (!any_held) begin
          if (out_free) begin
            emit_load             = 1'b1;
            emit_last             = 1'b1;
            emit_item.table_empty = 1'b1;
            emit_item.last_in_run = 1'b1;
            state_nxt             = BK_RUN;
          end
        end else if (held[emit_idx_r]) begin
          if (out_free) begin
            emit_load                 = 1'b1;
            emit_last                 = !any_above;
            emit_item.candidate_value = 32'(keys_r[emit_idx_r]);
            emit_item.candidate_count = 32'(cnt_r[emit_idx_r]);
            emit_item.last_in_run     = !any_above;
            if (!any_above) begin
              state_nxt    = BK_RUN;
              emit_idx_nxt = '0;
            end else begin
              emit_idx_nxt = emit_idx_r + IW'(1);
            end
          end
        end else begin
          emit_idx_nxt = emit_idx_r + IW'(1);
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  assign clear_all = cfg_clear || (emit_load && emit_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emit_idx_r <= emit_idx_nxt;
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) out_data_r <= emit_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_COUNTERS; i++) cnt_r[i] <= '0;
    end else if (clear_all) begin
      for (int i = 0; i < MAX_COUNTERS; i++) cnt_r[i] <= '0;
    end else if (do_absorb) begin
      for (int i = 0; i < MAX_COUNTERS; i++) begin
        if (any_match) begin
          if (match[i] && cnt_r[i] != CNT_MAX) cnt_r[i] <= cnt_r[i] + CNT_ONE;
        end else if (any_free) begin
          if (free_oh[i]) cnt_r[i] <= CNT_ONE;
        end else if (held[i]) begin
          cnt_r[i] <= cnt_r[i] - CNT_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_COUNTERS; i++) begin
      if (do_absorb && !any_match && free_oh[i]) keys_r[i] <= cmd_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "frequent_items_counter_summary_defines.svh"
  `FICS_ASSERT_ALWAYS(a_empty_last, !out_valid_r || !out_data_r.table_empty || out_data_r.last_in_run, "empty result not last")
  `FICS_ASSERT_NEXT(a_run_clears, emit_load && emit_last, !any_held, "table not cleared after run")
  `FICS_ASSERT_ALWAYS(a_held_active, (held & ~active) == '0, "slot held outside active range")
  `FICS_ASSERT_ALWAYS(a_idx_range, 32'(emit_idx_r) < MAX_COUNTERS, "scan index beyond table")

endmodule

### hw/rtl/frequent_items_counter_summary.sv
// Misra-Gries frequent-items summary. Items enter through a two-deep queue and
// each is absorbed by a match-and-update over all slots at once, so ordinary
// items sustain one per cycle while no result scan runs. An item with
// end_of_stream is absorbed and then the table is scanned one slot per cycle,
// holding at a held slot while the output stalls, emitting held keys in slot
// order (or a single empty-marked result); the table is freed as the last
// result is loaded. The queue keeps taking up to two items during a scan.
// num_counters (byte address 0) takes effect at once; writing it frees every
// slot in the same cycle, so there is no clearing pass after reset.
module frequent_items_counter_summary #(
  parameter int MAX_COUNTERS = 16,
  parameter int VALUE_WIDTH  = 32,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fics_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fics_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fics_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import fics_pkg::*;

  localparam int KW = $clog2(MAX_COUNTERS + 1);

  logic [4:0]             num_counters_r;
  logic                   cfg_hit, cfg_wr;
  logic [31:0]            k_wide;
  logic [KW-1:0]          k_eff;
  logic                   cmd_valid, cmd_take;
  logic [VALUE_WIDTH-1:0] cmd_value;
  op_t                    cmd_op;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_NUM_COUNTERS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cfg_prdata = cfg_hit ? {27'd0, num_counters_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_counters_r <= NUM_COUNTERS_RESET;
    end else if (cfg_wr) begin
      num_counters_r <= cfg_pwdata[4:0];
    end
  end

  // zero behaves as one, anything above the table size as the table size
  always_comb begin
    priority if (num_counters_r == 5'd0) begin
      k_wide = 32'd1;
    end else if (32'(num_counters_r) > MAX_COUNTERS) begin
      k_wide = 32'(MAX_COUNTERS);
    end else begin
      k_wide = 32'(num_counters_r);
    end
  end
  assign k_eff = k_wide[KW-1:0];

  fics_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_value (cmd_value),
    .cmd_op    (cmd_op)
  );

  fics_back #(
    .MAX_COUNTERS (MAX_COUNTERS),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .KW           (KW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .k_eff     (k_eff),
    .cfg_clear (cfg_wr),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_value (cmd_value),
    .cmd_op    (cmd_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sim/tb_frequent_items_counter_summary.sv
module tb_frequent_items_counter_summary;
  timeunit 1ns;
  timeprecision 1ps;

  import fics_pkg::*;

  localparam int SLOTS = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_AW-1:0] ADDR_NUM_COUNTERS = {REG_NUM_COUNTERS, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE = 3'd4;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  frequent_items_counter_summary #(
    .MAX_COUNTERS(SLOTS),
    .VALUE_WIDTH (32),
    .COUNT_WIDTH (32)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // summary state as the block should hold it
  logic [31:0] held_key   [SLOTS];
  logic [31:0] held_tally [SLOTS];
  logic [4:0]  k_setting;

  in_item_t  stream_q[$];
  out_item_t candidate_q[$];
  int        pushed_count = 0;
  int        taken_count = 0;
  int        fail_count = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;

  function automatic int live_slots();
    if (k_setting == 5'd0) return 1;
    if (k_setting > SLOTS) return SLOTS;
    return int'(k_setting);
  endfunction

  function automatic void clear_summary();
    for (int i = 0; i < SLOTS; i++) begin
      held_key[i]   = '0;
      held_tally[i] = '0;
    end
  endfunction

  function automatic void fold_value(logic [31:0] v);
    int k;
    int free_at;
    k = live_slots();
    free_at = -1;
    for (int i = 0; i < k; i++) begin
      if (held_tally[i] != 0 && held_key[i] == v) begin
        if (held_tally[i] != '1) held_tally[i] = held_tally[i] + 1;
        return;
      end
      if (held_tally[i] == 0 && free_at < 0) free_at = i;
    end
    if (free_at >= 0) begin
      held_key[free_at]   = v;
      held_tally[free_at] = 32'd1;
    end else begin
      // no match and no room: everyone loses one, value dropped
      for (int i = 0; i < k; i++) begin
        if (held_tally[i] != 0) held_tally[i] = held_tally[i] - 1;
      end
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t c;
    int        first;
    fold_value(it.item_value);
    if (!it.end_of_stream) return;
    first = candidate_q.size();
    for (int i = 0; i < SLOTS; i++) begin
      if (held_tally[i] != 0) begin
        c.candidate_value = held_key[i];
        c.candidate_count = held_tally[i];
        c.table_empty     = 1'b0;
        c.last_in_run     = 1'b0;
        candidate_q.push_back(c);
      end
    end
    if (candidate_q.size() == first) begin
      c = '0;
      c.table_empty = 1'b1;
      c.last_in_run = 1'b1;
      candidate_q.push_back(c);
    end else begin
      candidate_q[candidate_q.size()-1].last_in_run = 1'b1;
    end
    clear_summary();
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // driver: next transaction only once the current one has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (stream_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= stream_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: check results before predicting the input taken at the same edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (candidate_q.size() == 0) begin
          note_failure($sformatf("unexpected result: value %h count %h empty %b last %b",
                                 got.candidate_value, got.candidate_count,
                                 got.table_empty, got.last_in_run));
        end else begin
          want = candidate_q.pop_front();
          if (got.candidate_value !== want.candidate_value ||
              got.candidate_count !== want.candidate_count ||
              got.table_empty !== want.table_empty ||
              got.last_in_run !== want.last_in_run) begin
            note_failure($sformatf({"mismatch: expected value %h count %h empty %b last %b,",
                                    " got value %h count %h empty %b last %b"},
                                   want.candidate_value, want.candidate_count,
                                   want.table_empty, want.last_in_run,
                                   got.candidate_value, got.candidate_count,
                                   got.table_empty, got.last_in_run));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        taken_count++;
      end
    end
  end

  task automatic push_item(logic [31:0] v, op_t op);
    in_item_t it;
    it.item_value    = v;
    it.end_of_stream = (op == OP_ABSORB_EMIT);
    stream_q.push_back(it);
    pushed_count++;
  endtask

  // idle: every transaction taken, every result seen, then a settling pause
  task automatic wait_idle();
    while (taken_count != pushed_count || candidate_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_NUM_COUNTERS) begin
      k_setting = data[4:0];
      clear_summary();
    end
  endtask

  // a pool of likely values, one of them a heavy hitter, plus stray noise
  task automatic add_stream(int len);
    logic [31:0] pool [20];
    int          pool_size;
    logic [31:0] v;
    pool_size = $urandom_range(1, live_slots() + 3);
    for (int i = 0; i < pool_size; i++) begin
      case ($urandom_range(15))
        0:       pool[i] = '0;
        1:       pool[i] = '1;
        default: pool[i] = $urandom;
      endcase
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) v = $urandom;
      else if ($urandom_range(1) == 0) v = pool[0];
      else v = pool[$urandom_range(pool_size - 1)];
      push_item(v, (i == len - 1) ? OP_ABSORB_EMIT : OP_ABSORB);
    end
  endtask

  initial begin
    int          phase_items;
    int          len;
    logic [31:0] wdata;
    k_setting = NUM_COUNTERS_RESET;
    clear_summary();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, matches and fresh slots with all sixteen slots active
    push_item(32'h0000_0000, OP_ABSORB);
    push_item(32'hFFFF_FFFF, OP_ABSORB);
    push_item(32'h0000_0000, OP_ABSORB);
    push_item(32'h0000_0000, OP_ABSORB);
    push_item(32'hFFFF_FFFF, OP_ABSORB);
    push_item(32'h8000_0001, OP_ABSORB_EMIT);
    wait_idle();

    // one slot: eviction leaves an empty table at emission
    write_reg(ADDR_NUM_COUNTERS, 32'hFFFF_FFE1);
    push_item(32'h1234_5678, OP_ABSORB);
    push_item(32'h8765_4321, OP_ABSORB_EMIT);
    push_item(32'h5555_AAAA, OP_ABSORB);
    push_item(32'h5555_AAAA, OP_ABSORB);
    push_item(32'hAAAA_5555, OP_ABSORB);
    push_item(32'h5555_AAAA, OP_ABSORB_EMIT);
    wait_idle();

    // zero setting behaves as one slot
    write_reg(ADDR_NUM_COUNTERS, 32'h0000_0020);
    push_item(32'h0F0F_0F0F, OP_ABSORB);
    push_item(32'hF0F0_F0F0, OP_ABSORB);
    push_item(32'h0F0F_0F0F, OP_ABSORB_EMIT);
    wait_idle();

    // full table decrement; a write to the spare address must not clear slots
    write_reg(ADDR_NUM_COUNTERS, 32'd3);
    push_item(32'h0000_0011, OP_ABSORB);
    push_item(32'h0000_0022, OP_ABSORB);
    push_item(32'h0000_0033, OP_ABSORB);
    wait_idle();
    write_reg(ADDR_SPARE, 32'd1);
    push_item(32'h0000_0044, OP_ABSORB);
    push_item(32'h0000_0011, OP_ABSORB_EMIT);
    wait_idle();
    write_reg(ADDR_NUM_COUNTERS, 32'd31);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct   = 8;
          recv_stall_pct = 85;
        end
        1: begin
          send_gap_pct   = 85;
          recv_stall_pct = 8;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < 55) begin
        if ($urandom_range(2) == 0) begin
          wait_idle();
          wdata = $urandom;
          case ($urandom_range(7))
            0:       wdata[4:0] = 5'd0;
            1:       wdata[4:0] = 5'd1;
            2:       wdata[4:0] = 5'd16;
            3:       wdata[4:0] = 5'd31;
            4:       wdata[4:0] = 5'($urandom_range(17, 30));
            default: wdata[4:0] = 5'($urandom_range(2, 8));
          endcase
          write_reg(ADDR_NUM_COUNTERS, wdata);
        end
        len = ($urandom_range(5) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 14);
        add_stream(len);
        phase_items += len;
      end
    end

    wait_idle();
    if (fail_count == 0 && candidate_q.size() == 0) begin
      $display("frequent_items_counter_summary test passed");
    end else begin
      $display("frequent_items_counter_summary test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("frequent_items_counter_summary test failed");
    $finish;
  end

endmodule
